// ===== design/tbeq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tbeq_pkg
// Shared widths, register indexes, controller commands and the split
// multiplier used by the three-band equalizer.
// ----------------------------------------------------------------------------
package tbeq_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int STATE_FRAC_BITS = 16;
  localparam int POLE_W          = 40;
  localparam int COEF_W          = 18;
  localparam int GAIN_W          = 16;
  localparam int COEF_FRAC       = 16;
  localparam int GAIN_FRAC       = 12;
  localparam int N_STAGES        = 4;
  localparam int STAGE_W         = $clog2(N_STAGES);
  localparam int DELAY_LEN       = 3;
  localparam int OUT_LIMIT       = 22050;
  localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(4096);

  localparam int XS_W    = SAMPLE_WIDTH + STATE_FRAC_BITS;
  localparam int D_W     = ((POLE_W > XS_W) ? POLE_W : XS_W) + 1;
  localparam int B_W     = D_W + 2;
  localparam int LO_W    = 24;
  localparam int MUL_A_W = ((B_W - LO_W) > (LO_W + 1)) ? (B_W - LO_W) : (LO_W + 1);
  localparam int MUL_B_W = COEF_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;
  localparam int LACC_W  = D_W + COEF_W + 1;
  localparam int ACC_W   = B_W + GAIN_W + 3;
  localparam int RND_SH  = GAIN_FRAC + STATE_FRAC_BITS;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_COEF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_COEF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN = 3'd4;

  localparam int LANE_OP_W = 3;
  localparam logic [LANE_OP_W-1:0] LANE_NOP  = 3'd0;
  localparam logic [LANE_OP_W-1:0] LANE_LOAD = 3'd1;
  localparam logic [LANE_OP_W-1:0] LANE_DIFF = 3'd2;
  localparam logic [LANE_OP_W-1:0] LANE_MLO  = 3'd3;
  localparam logic [LANE_OP_W-1:0] LANE_MHI  = 3'd4;
  localparam logic [LANE_OP_W-1:0] LANE_ADD  = 3'd5;
  localparam logic [LANE_OP_W-1:0] LANE_UPD  = 3'd6;

  localparam int MAC_TERMS = 6;
  localparam int TERM_W    = $clog2(MAC_TERMS);

  typedef struct packed {
    logic                 load;
    logic                 pass;
    logic [LANE_OP_W-1:0] lane_op;
    logic [STAGE_W-1:0]   stage;
    logic                 band_h;
    logic                 band_m;
    logic                 mac_clear;
    logic                 mac_mul;
    logic [TERM_W-1:0]    mac_term;
    logic                 mac_acc;
    logic                 commit;
    logic                 emit;
  } tbeq_cmd_t;

  typedef struct packed {
    logic bypass;
    logic out_busy;
  } tbeq_status_t;

  typedef struct packed {
    logic [COEF_W-1:0] low_coef;
    logic [COEF_W-1:0] high_coef;
    logic [GAIN_W-1:0] low_gain;
    logic [GAIN_W-1:0] mid_gain;
    logic [GAIN_W-1:0] high_gain;
  } tbeq_cfg_t;

  function automatic logic signed [MUL_P_W-1:0] mul_part(
    input logic signed [MUL_A_W-1:0] a,
    input logic        [MUL_B_W-1:0] b
  );
    logic signed [MUL_B_W:0] bs;
    bs = $signed({1'b0, b});
    mul_part = a * bs;
  endfunction

endpackage
`default_nettype wire

// ===== design/tbeq_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tbeq_if
// Valid/ready channels of the equalizer: sample input, sample output and
// the register write port.
// ----------------------------------------------------------------------------
interface tbeq_in_if import tbeq_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface tbeq_out_if import tbeq_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface tbeq_cfg_if import tbeq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/tbeq_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tbeq_lane
// One cascade of four one-pole lowpass stages sharing a single split
// multiplier; each stage update runs over several controller steps.
// ----------------------------------------------------------------------------
module tbeq_lane import tbeq_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [LANE_OP_W-1:0]        op,
  input  logic [STAGE_W-1:0]          stage,
  input  logic [COEF_W-1:0]           coef,
  input  logic signed [D_W-1:0]       x_load,
  output logic signed [POLE_W-1:0]    last_pole
);

  localparam int SUM_W = LACC_W + 1;
  localparam logic signed [POLE_W-1:0] POLE_MAX = {1'b0, {(POLE_W-1){1'b1}}};
  localparam logic signed [POLE_W-1:0] POLE_MIN = {1'b1, {(POLE_W-1){1'b0}}};

  logic signed [POLE_W-1:0]  pole [N_STAGES];
  logic signed [D_W-1:0]     x;
  logic signed [D_W-1:0]     diff;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [LACC_W-1:0]  acc;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [SUM_W-1:0]   upd_sum;
  logic signed [POLE_W-1:0]  upd_pole;

  always_comb begin
    if (op == LANE_MHI) begin
      mul_a = MUL_A_W'($signed(diff[D_W-1:LO_W]));
    end else begin
      mul_a = $signed(MUL_A_W'(diff[LO_W-1:0]));
    end
    upd_sum = SUM_W'(pole[stage]) + SUM_W'(acc >>> COEF_FRAC);
    if (upd_sum > SUM_W'(POLE_MAX)) begin
      upd_pole = POLE_MAX;
    end else if (upd_sum < SUM_W'(POLE_MIN)) begin
      upd_pole = POLE_MIN;
    end else begin
      upd_pole = upd_sum[POLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N_STAGES; i++) begin
        pole[i] <= '0;
      end
    end else if (op == LANE_UPD) begin
      pole[stage] <= upd_pole;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      LANE_LOAD: x <= x_load;
      LANE_DIFF: diff <= x - D_W'(pole[stage]);
      LANE_MLO:  prod <= mul_part(mul_a, coef);
      LANE_MHI: begin
        prod <= mul_part(mul_a, coef);
        acc  <= LACC_W'(prod);
      end
      LANE_ADD:  acc <= acc + (LACC_W'(prod) <<< LO_W);
      LANE_UPD:  x <= D_W'(upd_pole);
      default: ;
    endcase
  end

  assign last_pole = pole[N_STAGES-1];

endmodule
`default_nettype wire

// ===== design/tbeq_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tbeq_datapath
// Both lowpass cascades, the delay line, band forming, the gain
// multiply-accumulate, rounding with saturation and the output register.
// ----------------------------------------------------------------------------
module tbeq_datapath import tbeq_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  tbeq_cmd_t                      cmd,
  output tbeq_status_t                   status,
  input  tbeq_cfg_t                      regs,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

  localparam logic [1:0] BAND_LOW = 2'd0;
  localparam logic [1:0] BAND_MID = 2'd1;

  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic signed [SAMPLE_WIDTH-1:0] delay [DELAY_LEN];
  logic signed [D_W-1:0]          x_load;
  logic signed [D_W-1:0]          old;
  logic signed [POLE_W-1:0]       low_last;
  logic signed [POLE_W-1:0]       high_last;
  logic signed [D_W-1:0]          h_band;
  logic signed [B_W-1:0]          m_band;
  logic signed [B_W-1:0]          band_val;
  logic        [GAIN_W-1:0]       band_gain;
  logic signed [MUL_A_W-1:0]      gmul_a;
  logic signed [MUL_P_W-1:0]      gprod;
  logic                           gprod_hi;
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        rnd;
  logic signed [ACC_W-1:0]        quot;
  logic signed [SAMPLE_WIDTH-1:0] clamped;
  logic signed [SAMPLE_WIDTH-1:0] result;

  assign x_load = D_W'(sample_in) <<< STATE_FRAC_BITS;
  assign old    = D_W'(delay[DELAY_LEN-1]) <<< STATE_FRAC_BITS;

  tbeq_lane u_low (
    .clk       (clk),
    .rst       (rst),
    .op        (cmd.lane_op),
    .stage     (cmd.stage),
    .coef      (regs.low_coef),
    .x_load    (x_load),
    .last_pole (low_last)
  );

  tbeq_lane u_high (
    .clk       (clk),
    .rst       (rst),
    .op        (cmd.lane_op),
    .stage     (cmd.stage),
    .coef      (regs.high_coef),
    .x_load    (x_load),
    .last_pole (high_last)
  );

  always_comb begin
    case (cmd.mac_term[TERM_W-1:1])
      BAND_LOW: begin
        band_val  = B_W'(low_last);
        band_gain = regs.low_gain;
      end
      BAND_MID: begin
        band_val  = m_band;
        band_gain = regs.mid_gain;
      end
      default: begin
        band_val  = B_W'(h_band);
        band_gain = regs.high_gain;
      end
    endcase
    if (cmd.mac_term[0]) begin
      gmul_a = MUL_A_W'($signed(band_val[B_W-1:LO_W]));
    end else begin
      gmul_a = $signed(MUL_A_W'(band_val[LO_W-1:0]));
    end
  end

  always_comb begin
    rnd  = acc + (ACC_W'(1) <<< (RND_SH - 1));
    quot = rnd >>> RND_SH;
    if (quot > ACC_W'(OUT_LIMIT)) begin
      clamped = SAMPLE_WIDTH'(OUT_LIMIT);
    end else if (quot < ACC_W'(-OUT_LIMIT)) begin
      clamped = SAMPLE_WIDTH'(-OUT_LIMIT);
    end else begin
      clamped = quot[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample <= sample_in;
    end
    if (cmd.band_h) begin
      h_band <= old - D_W'(high_last);
    end
    if (cmd.band_m) begin
      m_band <= B_W'(old) - (B_W'(h_band) + B_W'(low_last));
    end
    if (cmd.mac_mul) begin
      gprod    <= mul_part(gmul_a, MUL_B_W'(band_gain));
      gprod_hi <= cmd.mac_term[0];
    end
    if (cmd.mac_clear) begin
      acc <= '0;
    end else if (cmd.mac_acc) begin
      if (gprod_hi) begin
        acc <= acc + (ACC_W'(gprod) <<< LO_W);
      end else begin
        acc <= acc + ACC_W'(gprod);
      end
    end
    if (cmd.pass) begin
      result <= sample_in;
    end else if (cmd.commit) begin
      result <= clamped;
    end
    if (cmd.emit) begin
      sample_out <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DELAY_LEN; i++) begin
        delay[i] <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        for (int i = DELAY_LEN - 1; i > 0; i--) begin
          delay[i] <= delay[i-1];
        end
        delay[0] <= sample;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.bypass   = (regs.low_gain == GAIN_UNITY) && (regs.mid_gain == GAIN_UNITY)
                           && (regs.high_gain == GAIN_UNITY);
  assign status.out_busy = out_valid && !out_ready;

endmodule
`default_nettype wire

// ===== design/tbeq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tbeq_ctrl
// Sequencer for one sample: four cascade stages, band forming, six gain
// partial products, rounding and hand-off to the output register.
// ----------------------------------------------------------------------------
module tbeq_ctrl import tbeq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  tbeq_status_t status,
  output tbeq_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DIFF     = 4'd1;
  localparam logic [3:0] S_MLO      = 4'd2;
  localparam logic [3:0] S_MHI      = 4'd3;
  localparam logic [3:0] S_ADD      = 4'd4;
  localparam logic [3:0] S_UPD      = 4'd5;
  localparam logic [3:0] S_BAND_H   = 4'd6;
  localparam logic [3:0] S_BAND_M   = 4'd7;
  localparam logic [3:0] S_MAC      = 4'd8;
  localparam logic [3:0] S_MAC_LAST = 4'd9;
  localparam logic [3:0] S_ROUND    = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0]         state;
  logic [3:0]         state_next;
  logic [STAGE_W-1:0] stage;
  logic [STAGE_W-1:0] stage_next;
  logic [TERM_W-1:0]  term;
  logic [TERM_W-1:0]  term_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.stage    = stage;
    cmd.mac_term = term;
    state_next   = state;
    stage_next   = stage;
    term_next    = term;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (status.bypass) begin
            cmd.pass   = 1'b1;
            state_next = S_DONE;
          end else begin
            cmd.load    = 1'b1;
            cmd.lane_op = LANE_LOAD;
            stage_next  = '0;
            state_next  = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        cmd.lane_op = LANE_DIFF;
        state_next  = S_MLO;
      end
      S_MLO: begin
        cmd.lane_op = LANE_MLO;
        state_next  = S_MHI;
      end
      S_MHI: begin
        cmd.lane_op = LANE_MHI;
        state_next  = S_ADD;
      end
      S_ADD: begin
        cmd.lane_op = LANE_ADD;
        state_next  = S_UPD;
      end
      S_UPD: begin
        cmd.lane_op = LANE_UPD;
        if (stage == STAGE_W'(N_STAGES - 1)) begin
          state_next = S_BAND_H;
        end else begin
          stage_next = stage + 1'b1;
          state_next = S_DIFF;
        end
      end
      S_BAND_H: begin
        cmd.band_h    = 1'b1;
        cmd.mac_clear = 1'b1;
        state_next    = S_BAND_M;
      end
      S_BAND_M: begin
        cmd.band_m = 1'b1;
        term_next  = '0;
        state_next = S_MAC;
      end
      S_MAC: begin
        cmd.mac_mul = 1'b1;
        cmd.mac_acc = (term != '0);
        if (term == TERM_W'(MAC_TERMS - 1)) begin
          state_next = S_MAC_LAST;
        end else begin
          term_next = term + 1'b1;
        end
      end
      S_MAC_LAST: begin
        cmd.mac_acc = 1'b1;
        state_next  = S_ROUND;
      end
      S_ROUND: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stage <= '0;
      term  <= '0;
    end else begin
      state <= state_next;
      stage <= stage_next;
      term  <= term_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/three_band_equalizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// three_band_equalizer
// Three-band audio equalizer with register port, sequencer and datapath.
// ----------------------------------------------------------------------------
// A sample runs through four cascade stages (difference, low and high
// partial products, add, pole update), run in lockstep by both lowpass lanes
// on their own 25x18 split multipliers, then band forming, six gain
// multiply-accumulate terms and rounding into the result register. The
// sequencer waits for a free output register, hands the result off and
// only then goes idle to take the next sample. With all three gains at unity
// a sample passes straight to the result register and no filter state
// changes. A new sample is taken while the previous result still waits on
// the output. The register port is always ready; the user must write
// registers only while no sample is in flight. The block does not enforce it.
module three_band_equalizer import tbeq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  tbeq_in_if.sink           din,
  tbeq_out_if.source        dout,
  tbeq_cfg_if.sink          cfg
);

  tbeq_cfg_t    regs;
  tbeq_cmd_t    cmd;
  tbeq_status_t status;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.low_coef  <= '0;
      regs.high_coef <= '0;
      regs.low_gain  <= GAIN_UNITY;
      regs.mid_gain  <= GAIN_UNITY;
      regs.high_gain <= GAIN_UNITY;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LOW_COEF:  regs.low_coef  <= cfg.data[COEF_W-1:0];
        REG_HIGH_COEF: regs.high_coef <= cfg.data[COEF_W-1:0];
        REG_LOW_GAIN:  regs.low_gain  <= cfg.data[GAIN_W-1:0];
        REG_MID_GAIN:  regs.mid_gain  <= cfg.data[GAIN_W-1:0];
        REG_HIGH_GAIN: regs.high_gain <= cfg.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  tbeq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tbeq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .regs       (regs),
    .sample_in  (din.sample_in),
    .out_ready  (dout.ready),
    .out_valid  (dout.valid),
    .sample_out (dout.sample_out)
  );

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |=> !din.ready)
    else $error("Input stayed ready after a sample beat.");

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !status.out_busy)
    else $error("Result emitted over an unaccepted output beat.");

  a_one_phase: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.pass, cmd.commit, cmd.emit}))
    else $error("Conflicting sequencer commands in one cycle.");

endmodule
`default_nettype wire
